// File: rtl/core/dbhs_pkg.sv
// ---------------------------------------------------------------------------
// dbhs_pkg
// Shared types and constants of the database handshake health checker.
// ---------------------------------------------------------------------------
`default_nettype none

package dbhs_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int VERD_W   = 3;
  localparam int CAUSE_W  = 4;
  localparam int COUNT_W  = 25;
  localparam int LEN_W    = 24;
  localparam int POS_W    = COUNT_W + 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;

  // Protocol constants
  localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [BYTE_W-1:0]  PROTO_VERSION  = 8'd10;
  localparam int                 CAP_HIGH_BIT   = 1;   // bit 0x0200 of the capability word
  localparam int                 CAP_OFFSET     = 1 + 4 + 8 + 1;
  localparam int                 LEN_FIELD_BYTES = 3;
  localparam int                 HDR_BYTES      = 4;
  localparam int                 MIN_BYTES      = 5;
  localparam int                 OK_MIN_BYTES   = 7;
  localparam int                 NUL_START      = 5;
  localparam logic [BYTE_W-1:0]  SEQ_GREETING   = 8'd0;
  localparam logic [BYTE_W-1:0]  SEQ_REPLY      = 8'd2;
  localparam logic [BYTE_W-1:0]  REPLY_OK_CODE  = 8'd0;

  // Result buffer depth default
  localparam int RES_DEPTH_DEF = 3;

  typedef enum logic [2:0] {
    PH_GREETING = 3'b001,
    PH_REPLY    = 3'b010,
    PH_OVER     = 3'b100
  } phase_t;

  typedef enum logic [VERD_W-1:0] {
    VD_GREETING_OK = 3'd0,
    VD_PASSED      = 3'd1,
    VD_ACTIVE_FAIL = 3'd2,
    VD_NET_FAIL    = 3'd3,
    VD_IGNORED     = 3'd4
  } verdict_t;

  typedef enum logic [CAUSE_W-1:0] {
    FC_NONE       = 4'd0,
    FC_SHORT      = 4'd1,
    FC_LEN        = 4'd2,
    FC_SEQUENCE   = 4'd3,
    FC_VERSION    = 4'd4,
    FC_NO_NUL     = 4'd5,
    FC_SHORT_CAPS = 4'd6,
    FC_NO_41      = 4'd7,
    FC_NOT_OK     = 4'd8
  } cause_t;

  typedef struct packed {
    verdict_t verdict;
    cause_t   cause;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/dbhs_core.sv
// ---------------------------------------------------------------------------
// dbhs_core
// Phase tracking, per-chunk header capture and end-of-chunk checks.
// ---------------------------------------------------------------------------
`default_nettype none

module dbhs_core import dbhs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire logic [OP_W-1:0]   item_op,
  input  wire logic [BYTE_W-1:0] item_byte,
  input  wire logic              item_end,
  output logic                   res_valid,
  output res_t                   res
);

  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] cnt_r, c_cnt;
  logic [LEN_W-1:0]   len_r, c_len;
  logic [BYTE_W-1:0]  seq_r, c_seq;
  logic [BYTE_W-1:0]  first_r, c_first;
  logic               found_r, c_found;
  logic [POS_W-1:0]   cap_pos_r, c_cap_pos;   // NUL position + CAP_OFFSET + 1
  logic [BYTE_W-1:0]  caphi_r, c_caphi;

  logic               is_data, take, clear;
  logic [POS_W-1:0]   cnt_ext, len_plus_hdr;
  logic               len_bad;
  cause_t             g_cause, r_cause;

  assign is_data = item_valid && (item_op == OP_DATA);
  assign take    = is_data && (cnt_r != COUNT_MAX);
  assign clear   = item_valid && ((item_op == OP_TICK) || (item_op == OP_CLOSE) ||
                                  (item_op == OP_DATA && item_end));

  // Captured view of the chunk including the current byte
  always_comb begin
    c_cnt     = cnt_r;
    c_len     = len_r;
    c_seq     = seq_r;
    c_first   = first_r;
    c_found   = found_r;
    c_cap_pos = cap_pos_r;
    c_caphi   = caphi_r;
    if (take) begin
      c_cnt = cnt_r + 1'b1;
      if (cnt_r < COUNT_W'(LEN_FIELD_BYTES)) begin
        c_len = len_r | (LEN_W'(item_byte) << {cnt_r[1:0], 3'b000});
      end else if (cnt_r == COUNT_W'(HDR_BYTES - 1)) begin
        c_seq = item_byte;
      end else if (cnt_r == COUNT_W'(HDR_BYTES)) begin
        c_first = item_byte;
      end
      if (cnt_r >= COUNT_W'(NUL_START) && !found_r && item_byte == '0) begin
        c_found   = 1'b1;
        c_cap_pos = {1'b0, cnt_r} + POS_W'(CAP_OFFSET + 1);
      end
      if (found_r && ({1'b0, cnt_r} == cap_pos_r)) begin
        c_caphi = item_byte;
      end
    end
  end

  assign cnt_ext      = {1'b0, c_cnt};
  assign len_plus_hdr = {{(POS_W-LEN_W){1'b0}}, c_len} + POS_W'(HDR_BYTES);
  assign len_bad      = (cnt_ext != len_plus_hdr);

  always_comb begin
    if (c_cnt < COUNT_W'(MIN_BYTES))           g_cause = FC_SHORT;
    else if (len_bad)                          g_cause = FC_LEN;
    else if (c_seq != SEQ_GREETING)            g_cause = FC_SEQUENCE;
    else if (c_first != PROTO_VERSION)         g_cause = FC_VERSION;
    else if (!c_found)                         g_cause = FC_NO_NUL;
    else if (cnt_ext <= c_cap_pos)             g_cause = FC_SHORT_CAPS;
    else if (!c_caphi[CAP_HIGH_BIT])           g_cause = FC_NO_41;
    else                                       g_cause = FC_NONE;
  end

  always_comb begin
    if (c_cnt < COUNT_W'(MIN_BYTES))           r_cause = FC_SHORT;
    else if (len_bad)                          r_cause = FC_LEN;
    else if (c_seq != SEQ_REPLY)               r_cause = FC_SEQUENCE;
    else if (c_first != REPLY_OK_CODE || c_cnt < COUNT_W'(OK_MIN_BYTES))
                                               r_cause = FC_NOT_OK;
    else                                       r_cause = FC_NONE;
  end

  always_comb begin
    phase_nxt   = phase_r;
    res_valid   = 1'b0;
    res.verdict = VD_IGNORED;
    res.cause   = FC_NONE;
    if (item_valid && item_op == OP_TICK) begin
      phase_nxt = PH_GREETING;
    end else if (item_valid && item_op == OP_CLOSE) begin
      if (phase_r == PH_GREETING || phase_r == PH_REPLY) begin
        res_valid   = 1'b1;
        res.verdict = VD_NET_FAIL;
      end
    end else if (is_data && item_end) begin
      res_valid = 1'b1;
      unique case (phase_r)
        PH_GREETING: begin
          res.cause = g_cause;
          if (g_cause == FC_NONE) begin
            res.verdict = VD_GREETING_OK;
            phase_nxt   = PH_REPLY;
          end else begin
            res.verdict = VD_ACTIVE_FAIL;
            phase_nxt   = PH_OVER;
          end
        end
        PH_REPLY: begin
          res.cause   = r_cause;
          res.verdict = (r_cause == FC_NONE) ? VD_PASSED : VD_ACTIVE_FAIL;
          phase_nxt   = PH_OVER;
        end
        default: begin
          res.verdict = VD_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_GREETING;
      cnt_r     <= '0;
      len_r     <= '0;
      seq_r     <= '0;
      first_r   <= '0;
      found_r   <= 1'b0;
      cap_pos_r <= '0;
      caphi_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (clear) begin
        cnt_r     <= '0;
        len_r     <= '0;
        seq_r     <= '0;
        first_r   <= '0;
        found_r   <= 1'b0;
        cap_pos_r <= '0;
        caphi_r   <= '0;
      end else if (take) begin
        cnt_r     <= c_cnt;
        len_r     <= c_len;
        seq_r     <= c_seq;
        first_r   <= c_first;
        found_r   <= c_found;
        cap_pos_r <= c_cap_pos;
        caphi_r   <= c_caphi;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dbhs_res_fifo.sv
// ---------------------------------------------------------------------------
// dbhs_res_fifo
// Small result buffer between the check logic and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module dbhs_res_fifo import dbhs_pkg::*; #(
  parameter int DEPTH = RES_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire res_t                       wr_data,
  input  wire logic                       rd_en,
  output logic                            rd_valid,
  output res_t                            rd_data,
  output logic [$clog2(DEPTH+1)-1:0]      fill
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_rd;

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign fill     = cnt_r;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({wr_en, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/db_handshake_health_checker_top.sv
// ---------------------------------------------------------------------------
// db_handshake_health_checker_top
// Checks a server greeting and login reply, one received byte per cycle unless stalled.
// ---------------------------------------------------------------------------
//  Channel   Direction  Ports                                       Flow
//  in_       input      in_operation, in_data_byte, in_chunk_end    in_valid / in_stall
//  out_      output     out_verdict, out_fail_cause                 out_valid / out_stall
//
//  One transfer per cycle is taken on in_ when the result buffer has room.
//  A result reaches out_ via the input register, then the checks and the buffer.
//  in_stall rises only when the result buffer could overflow (RES_DEPTH).
//  Reset is synchronous; it returns to the greeting phase, empties the buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module db_handshake_health_checker_top import dbhs_pkg::*; #(
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [BYTE_W-1:0]  in_data_byte,
  input  wire logic               in_chunk_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [VERD_W-1:0]       out_verdict,
  output logic [CAUSE_W-1:0]      out_fail_cause
);

  localparam int CW = $clog2(RES_DEPTH + 1);

  logic              in_valid_r;
  logic [OP_W-1:0]   op_r;
  logic [BYTE_W-1:0] byte_r;
  logic              end_r;
  logic              res_valid;
  res_t              res;
  res_t              head;
  logic [CW-1:0]     fill;
  logic [CW:0]       pending;

  // Reserve room for the item held in the input register and one more
  assign pending  = {1'b0, fill} + (CW+1)'(in_valid_r);
  assign in_stall = (pending >= (CW+1)'(RES_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= in_operation;
      byte_r <= in_data_byte;
      end_r  <= in_chunk_end;
    end
  end

  dbhs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item_op    (op_r),
    .item_byte  (byte_r),
    .item_end   (end_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  dbhs_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_en    (!out_stall),
    .rd_valid (out_valid),
    .rd_data  (head),
    .fill     (fill)
  );

  assign out_verdict    = head.verdict;
  assign out_fail_cause = head.cause;

endmodule

`default_nettype wire

// File: rtl/core/dbhs_checker.sv
// ---------------------------------------------------------------------------
// dbhs_checker
// Port-level checks on the handshake health checker, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module dbhs_checker import dbhs_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [VERD_W-1:0]  out_verdict,
  input wire logic [CAUSE_W-1:0] out_fail_cause
);

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A cause is only reported with an active failure
  a_cause_only_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict != VD_ACTIVE_FAIL) |-> (out_fail_cause == FC_NONE))
    else $error("fail cause without active fail");

  // An active failure always names a cause
  a_fail_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VD_ACTIVE_FAIL) |->
      (out_fail_cause != FC_NONE && out_fail_cause <= FC_NOT_OK))
    else $error("active fail without a valid cause");

  // A stalled result stays offered and unchanged
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_verdict) && $stable(out_fail_cause)))
    else $error("stalled result dropped or changed");

endmodule

bind db_handshake_health_checker_top dbhs_checker u_dbhs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_verdict    (out_verdict),
  .out_fail_cause (out_fail_cause)
);

`default_nettype wire
